// ===== src/swat_pkg.sv =====
// shared constants, codes and control types for the send window ack tracker
package swat_pkg;

  localparam int WINDOW_SIZE = 8;
  localparam int IDX_W = $clog2(WINDOW_SIZE);
  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam logic [CNT_W-1:0] WINDOW_COUNT = CNT_W'(WINDOW_SIZE);

  localparam int SEQ_W = 32;
  localparam int THR_W = 4;
  localparam int STATUS_W = 3;
  localparam int OUT_CNT_W = 4;

  localparam logic [THR_W-1:0] DUP_THRESHOLD_RESET = 4'd3;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_ACK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SLID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSLIDE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FASTRTX = 3'd5;

  typedef struct packed {
    logic load;
    logic eval;
    logic shift;
    logic commit;
  } swat_ctl_t;

  typedef struct packed {
    logic shift_pending;
    logic out_free;
  } swat_sts_t;

endpackage

// ===== src/swat_ctrl.sv =====
// sequencing state machine for the send window ack tracker
module swat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  swat_pkg::swat_sts_t sts,
  output swat_pkg::swat_ctl_t ctl
);

  typedef enum logic [1:0] {
    IDLE,
    EVAL,
    SHIFT
  } state_t;

  state_t state;

  always_comb begin
    ctl.load = (state == IDLE) && in_valid && in_ready;
    ctl.eval = (state == EVAL);
    ctl.shift = (state == SHIFT) && sts.shift_pending;
    ctl.commit = (state == SHIFT) && !sts.shift_pending && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      in_ready <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            state <= EVAL;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        EVAL: begin
          state <= SHIFT;
        end
        SHIFT: begin
          if (!sts.shift_pending && sts.out_free) begin
            state <= IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/swat_datapath.sv =====
// window registers, ack search, slide and result register
module swat_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  swat_pkg::swat_ctl_t                 ctl,
  output swat_pkg::swat_sts_t                 sts,
  input  logic                                cfg_wr_en,
  input  logic [swat_pkg::THR_W-1:0]          cfg_wr_data,
  input  logic                                command,
  input  logic [swat_pkg::SEQ_W-1:0]          seq_num,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swat_pkg::STATUS_W-1:0]       status,
  output logic                                fast_retransmit,
  output logic [swat_pkg::OUT_CNT_W-1:0]      free_slots,
  output logic [swat_pkg::OUT_CNT_W-1:0]      released_count,
  output logic                                window_empty,
  output logic [swat_pkg::SEQ_W-1:0]          oldest_seq
);

  logic [swat_pkg::SEQ_W-1:0] entries [swat_pkg::WINDOW_SIZE];
  logic [swat_pkg::CNT_W-1:0] occ;
  logic [swat_pkg::SEQ_W-1:0] last_ack;
  logic [swat_pkg::THR_W-1:0] dup_count;
  logic [swat_pkg::THR_W-1:0] threshold;

  logic                       cmd_r;
  logic [swat_pkg::SEQ_W-1:0] seq_r;
  logic [swat_pkg::CNT_W-1:0] rel;
  logic [swat_pkg::CNT_W-1:0] shift_left;

  // first matching outstanding entry
  logic                       hit;
  logic [swat_pkg::IDX_W-1:0] hit_idx;

  logic                       is_new_ack;
  logic [swat_pkg::CNT_W-1:0] occ_next;
  logic [swat_pkg::THR_W-1:0] dup_next;
  logic [swat_pkg::THR_W-1:0] dup_inc;
  logic [swat_pkg::STATUS_W-1:0] status_next;
  logic [swat_pkg::CNT_W-1:0] released_next;
  logic [swat_pkg::SEQ_W-1:0] head_next;
  logic                       do_write;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = swat_pkg::WINDOW_SIZE - 1; i >= 0; i--) begin
      if ((swat_pkg::CNT_W'(i) < occ) && (entries[i] == seq_r)) begin
        hit = 1'b1;
        hit_idx = swat_pkg::IDX_W'(i);
      end
    end
  end

  assign is_new_ack = (cmd_r == swat_pkg::CMD_ACK) && (seq_r != last_ack);
  assign sts.shift_pending = (shift_left != '0);
  assign sts.out_free = !out_valid || out_ready;
  assign dup_inc = dup_count + swat_pkg::THR_W'(1);

  always_comb begin
    occ_next = occ;
    dup_next = dup_count;
    status_next = swat_pkg::ST_STORED;
    released_next = '0;
    do_write = 1'b0;
    head_next = entries[0];
    if (cmd_r == swat_pkg::CMD_SEND) begin
      if (occ >= swat_pkg::WINDOW_COUNT) begin
        status_next = swat_pkg::ST_FULL;
      end else begin
        do_write = 1'b1;
        occ_next = occ + swat_pkg::CNT_W'(1);
        status_next = swat_pkg::ST_STORED;
        if (occ == '0) begin
          head_next = seq_r;
        end
      end
    end else if (is_new_ack) begin
      dup_next = '0;
      if (rel == '0) begin
        status_next = swat_pkg::ST_NOSLIDE;
      end else begin
        occ_next = occ - rel;
        released_next = rel;
        status_next = swat_pkg::ST_SLID;
      end
    end else begin
      if (dup_inc >= threshold) begin
        dup_next = '0;
        status_next = swat_pkg::ST_FASTRTX;
      end else begin
        dup_next = dup_inc;
        status_next = swat_pkg::ST_DUP;
      end
    end
  end

  // window contents carry no reset, only entries below occ are read
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int k = 0; k < swat_pkg::WINDOW_SIZE - 1; k++) begin
        entries[k] <= entries[k + 1];
      end
    end else if (ctl.commit && do_write) begin
      entries[occ[swat_pkg::IDX_W-1:0]] <= seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= command;
      seq_r <= seq_num;
    end
    if (ctl.eval) begin
      rel <= hit ? swat_pkg::CNT_W'(hit_idx) : occ;
    end
    if (ctl.commit) begin
      status <= status_next;
      fast_retransmit <= (status_next == swat_pkg::ST_FASTRTX);
      free_slots <= swat_pkg::OUT_CNT_W'(swat_pkg::WINDOW_COUNT - occ_next);
      released_count <= swat_pkg::OUT_CNT_W'(released_next);
      window_empty <= (occ_next == '0);
      oldest_seq <= (occ_next != '0) ? head_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      last_ack <= '0;
      dup_count <= '0;
      threshold <= swat_pkg::DUP_THRESHOLD_RESET;
      shift_left <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      // slide only when a later entry matched
      if (ctl.eval) begin
        shift_left <= ((cmd_r == swat_pkg::CMD_ACK) && (seq_r != last_ack) && hit)
                      ? swat_pkg::CNT_W'(hit_idx) : '0;
      end else if (ctl.shift) begin
        shift_left <= shift_left - swat_pkg::CNT_W'(1);
      end
      if (ctl.commit) begin
        occ <= occ_next;
        dup_count <= dup_next;
        if (is_new_ack) begin
          last_ack <= seq_r;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/send_window_ack_tracker_top.sv =====
// top level of the send window ack tracker
//
// sender side of a sliding window of eight sequence numbers. the input
// channel (in_valid/in_ready) carries command and seq_num: a send appends
// seq_num at the tail, an ack releases entries up to the matching one or
// counts as a duplicate of the last ack. every input transfer gives exactly
// one result transfer on the output channel (out_valid/out_ready).
// one item is handled at a time. each item passes through EVAL and then
// SHIFT, where the entries ahead of a matching ack (0 to 7) slide out
// before the result loads: the window registers move one place per cycle.
// the next item can be taken in the cycle after the result is loaded.
// the result sits in an output register; while the receiver stalls the
// block still takes the next item and works it up to the final step, where
// it waits for the register to free.
// dup_ack_threshold is written through cfg_wr_en/cfg_wr_data at any edge outside reset.
// synchronous reset empties the window, clears last ack and duplicate count
// and sets the threshold to 3.
module send_window_ack_tracker_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [swat_pkg::THR_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [swat_pkg::SEQ_W-1:0]        seq_num,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [swat_pkg::STATUS_W-1:0]     status,
  output logic                              fast_retransmit,
  output logic [swat_pkg::OUT_CNT_W-1:0]    free_slots,
  output logic [swat_pkg::OUT_CNT_W-1:0]    released_count,
  output logic                              window_empty,
  output logic [swat_pkg::SEQ_W-1:0]        oldest_seq
);

  swat_pkg::swat_ctl_t ctl;
  swat_pkg::swat_sts_t sts;

  swat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  swat_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .command         (command),
    .seq_num         (seq_num),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .fast_retransmit (fast_retransmit),
    .free_slots      (free_slots),
    .released_count  (released_count),
    .window_empty    (window_empty),
    .oldest_seq      (oldest_seq)
  );

endmodule

// ===== src/swat_checker.sv =====
// port level checks for the send window ack tracker, bound to the top level
module swat_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [swat_pkg::STATUS_W-1:0]     status,
  input logic                              fast_retransmit,
  input logic [swat_pkg::OUT_CNT_W-1:0]    free_slots,
  input logic [swat_pkg::OUT_CNT_W-1:0]    released_count,
  input logic                              window_empty,
  input logic [swat_pkg::SEQ_W-1:0]        oldest_seq
);

  // no result survives reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fast_retransmit == (status == swat_pkg::ST_FASTRTX)))
    else $error("fast retransmit flag disagrees with status");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && window_empty) |->
      (oldest_seq == '0) && (free_slots == swat_pkg::OUT_CNT_W'(swat_pkg::WINDOW_SIZE)))
    else $error("empty window reports a head or missing slots");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (released_count != '0)) |-> (status == swat_pkg::ST_SLID))
    else $error("entries released without a slide");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(oldest_seq)))
    else $error("stalled result changed");

endmodule

bind send_window_ack_tracker_top swat_checker u_swat_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .status          (status),
  .fast_retransmit (fast_retransmit),
  .free_slots      (free_slots),
  .released_count  (released_count),
  .window_empty    (window_empty),
  .oldest_seq      (oldest_seq)
);
